// File: hw/rtl/tsde_pkg.sv
package tsde_pkg;

	// marker and window geometry
	localparam int MARK_LEN    = 29;
	localparam int TAIL_MARGIN = 64;
	localparam int POS_BITS    = 32;
	localparam int CFG_BITS    = 32;
	localparam int VALUE_BITS  = 64;
	localparam int BYTE_BITS   = 8;
	localparam int NEED_LEN    = MARK_LEN + TAIL_MARGIN;

	localparam logic [MARK_LEN*BYTE_BITS-1:0] MARKER = "UUUBURNXXOEUZX7+A-XY5601QQWWZ";

	// configuration register indexes
	localparam logic [1:0] CFG_SCAN_START    = 2'd0;
	localparam logic [1:0] CFG_SCAN_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_BUFFER_LENGTH = 2'd2;

	// position counters
	localparam logic [POS_BITS-1:0] POS_MAX   = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] CAND_INIT = POS_BITS'(0) - POS_BITS'(MARK_LEN - 1);
	localparam logic [POS_BITS-1:0] CAND_SAT  = POS_MAX - POS_BITS'(MARK_LEN - 1);

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_LEAD,
		PH_DIGITS,
		PH_DONE
	} phase_t;

endpackage

// File: hw/rtl/tsde_if.sv
// input byte channel
interface tsde_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// result channel
interface tsde_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] match_position;
	logic [63:0] parsed_value;

	modport source (output valid, output found, output match_position,
		output parsed_value, input ready);
	modport sink   (input valid, input found, input match_position,
		input parsed_value, output ready);
endinterface

// File: hw/rtl/tag_scan_decimal_extract.sv
// Channel   Dir  Beat contents                               Handshake
// in_ch     in   data_byte[7:0], last_byte                   valid/ready
// out_ch    out  found, match_position[31:0], parsed_value   valid/ready
// cfg       in   cfg_index[1:0], cfg_data[31:0]              cfg_we, no wait
//
// One byte per cycle while the input side is not stalled. A result is valid once the
// beat carrying last_byte has passed the input register and then the result register.
// The input side stalls only while a final-byte beat waits in the input
// register and the result register still holds an untaken result.
// Reset clears all control state at once; there is no clearing pass.
module tag_scan_decimal_extract (
	input  logic                          clk,
	input  logic                          arst_n,
	tsde_in_if.sink                       in_ch,
	tsde_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [tsde_pkg::CFG_BITS-1:0] cfg_data
);
	import tsde_pkg::*;

	// configuration and derived window bound
	logic [CFG_BITS-1:0] scan_start_q;
	logic [CFG_BITS-1:0] scan_limit_q;
	logic [CFG_BITS-1:0] buffer_length_q;
	logic                win_ok_q;
	logic [CFG_BITS-1:0] win_end_q;

	// input register
	logic                 valid_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 last_s1;

	// per-buffer state
	logic [MARK_LEN*BYTE_BITS-1:0] win_q;
	logic [POS_BITS-1:0]           cand_q;
	logic                          full_q;
	phase_t                        phase_q;
	phase_t                        phase_d;
	logic [VALUE_BITS-1:0]         acc_q;
	logic                          neg_q;
	logic [POS_BITS-1:0]           found_pos_q;

	// result register
	logic                  out_valid_q;
	logic                  out_found_q;
	logic [POS_BITS-1:0]   out_pos_q;
	logic [VALUE_BITS-1:0] out_value_q;

	// datapath signals
	logic                          step;
	logic                          advance;
	logic [MARK_LEN*BYTE_BITS-1:0] win_d;
	logic                          is_space;
	logic                          is_digit;
	logic                          is_sign;
	logic                          hit;
	logic [VALUE_BITS-1:0]         digit_ext;
	logic [VALUE_BITS-1:0]         acc_step;
	logic [VALUE_BITS-1:0]         acc_d;
	logic                          neg_d;
	logic [POS_BITS-1:0]           found_pos_d;

	// effective window length: the smaller of limit and length, taking in a write to either
	logic [CFG_BITS-1:0] eff_len;
	always_comb begin
		eff_len = scan_limit_q < buffer_length_q ? scan_limit_q : buffer_length_q;
		if (cfg_index == CFG_SCAN_LIMIT) begin
			eff_len = cfg_data < buffer_length_q ? cfg_data : buffer_length_q;
		end else if (cfg_index == CFG_BUFFER_LENGTH) begin
			eff_len = scan_limit_q < cfg_data ? scan_limit_q : cfg_data;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_start_q    <= '0;
			scan_limit_q    <= '1;
			buffer_length_q <= '0;
			win_ok_q        <= 1'b0;
			win_end_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCAN_START:    scan_start_q <= cfg_data;
				CFG_SCAN_LIMIT:    scan_limit_q <= cfg_data;
				CFG_BUFFER_LENGTH: buffer_length_q <= cfg_data;
				default: ;
			endcase
			if (cfg_index == CFG_SCAN_LIMIT || cfg_index == CFG_BUFFER_LENGTH) begin
				win_ok_q  <= eff_len >= CFG_BITS'(NEED_LEN);
				win_end_q <= eff_len - CFG_BITS'(NEED_LEN);
			end
		end
	end

	// handshake: only a final byte waits for the result register
	assign advance     = !last_s1 || !out_valid_q || out_ch.ready;
	assign step        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// byte classes
	always_comb begin
		is_space = 1'b0;
		is_digit = 1'b0;
		is_sign  = 1'b0;
		case (byte_s1) inside
			[8'd9:8'd13], 8'd32: is_space = 1'b1;
			[8'd48:8'd57]:       is_digit = 1'b1;
			8'd43, 8'd45:        is_sign  = 1'b1;
			default: ;
		endcase
	end

	// marker compare on the shifted window
	assign win_d = {win_q[(MARK_LEN-1)*BYTE_BITS-1:0], byte_s1};
	assign hit   = full_q && (win_d == MARKER) && win_ok_q &&
		(cand_q >= scan_start_q) && (cand_q < win_end_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_SEARCH: begin
				if (hit) phase_d = PH_LEAD;
			end
			PH_LEAD: begin
				if (is_sign || is_digit) phase_d = PH_DIGITS;
				else if (!is_space)      phase_d = PH_DONE;
			end
			PH_DIGITS: begin
				if (!is_digit) phase_d = PH_DONE;
			end
			default: ;
		endcase
	end

	// accumulator keeps the signed value: acc*10 +/- digit
	assign digit_ext = VALUE_BITS'(byte_s1 - 8'd48);
	assign acc_step  = (acc_q << 3) + (acc_q << 1) +
		(neg_q ? (~digit_ext + VALUE_BITS'(1)) : digit_ext);

	always_comb begin
		acc_d       = acc_q;
		neg_d       = neg_q;
		found_pos_d = found_pos_q;
		case (phase_q)
			PH_SEARCH: begin
				if (hit) found_pos_d = cand_q;
			end
			PH_LEAD: begin
				if (is_sign)       neg_d = (byte_s1 == 8'd45);
				else if (is_digit) acc_d = digit_ext;
			end
			PH_DIGITS: begin
				if (is_digit) acc_d = acc_step;
			end
			default: ;
		endcase
	end

	// per-buffer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q      <= CAND_INIT;
			full_q      <= 1'b0;
			phase_q     <= PH_SEARCH;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			found_pos_q <= '0;
		end else if (step) begin
			if (last_s1) begin
				cand_q      <= CAND_INIT;
				full_q      <= 1'b0;
				phase_q     <= PH_SEARCH;
				acc_q       <= '0;
				neg_q       <= 1'b0;
				found_pos_q <= '0;
			end else begin
				if (cand_q != CAND_SAT) cand_q <= cand_q + POS_BITS'(1);
				full_q      <= full_q || (cand_q == POS_MAX);
				phase_q     <= phase_d;
				acc_q       <= acc_d;
				neg_q       <= neg_d;
				found_pos_q <= found_pos_d;
			end
		end
	end

	// byte window shifts only while searching; the compare is gated by full_q
	always_ff @(posedge clk) begin
		if (step && phase_q == PH_SEARCH) begin
			win_q <= win_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_found_q <= phase_d != PH_SEARCH;
			out_pos_q   <= (phase_d != PH_SEARCH) ? found_pos_d : '0;
			out_value_q <= (phase_d != PH_SEARCH) ? acc_d : '0;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.found          = out_found_q;
	assign out_ch.match_position = out_pos_q;
	assign out_ch.parsed_value   = out_value_q;

	// input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (valid_s1 && last_s1 && out_valid_q && !out_ch.ready))
		else $error("input stalled without a pending result");

	// a not-found result carries zero payload
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_pos_q == '0 && out_value_q == '0))
		else $error("not-found result with nonzero payload");

	// while searching, the number state stays clear
	a_search_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEARCH) |-> (acc_q == '0 && !neg_q && found_pos_q == '0))
		else $error("number state set while searching");

	// a final beat returns the buffer state to its start
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> (phase_q == PH_SEARCH && !full_q && cand_q == CAND_INIT))
		else $error("buffer state not cleared after final byte");

endmodule
